// File: sv/rtg_pkg.sv
// Shared types and constants of the reference trajectory generator.
// Holds fixed-point constants, the CORDIC angle table and the cell beat struct.
// No dependencies.
package rtg_pkg;

  localparam int MaxHorizonDefault   = 64;
  localparam int CordicStagesDefault = 16;
  localparam int ResultCap           = 64;

  localparam logic signed [19:0] PiQ16     = 20'sd205887;
  localparam logic signed [19:0] HalfPiQ16 = 20'sd102944;
  localparam logic [18:0]        TwoPiQ16  = 19'd411775;
  localparam logic [31:0]        WCircle   = 32'd858993459;
  localparam logic [31:0]        WSine     = 32'd1288490189;
  localparam logic signed [33:0] OneQ30    = 34'sd1073741824;
  localparam logic signed [33:0] GainQ30   = 34'sd652032875;
  localparam logic [15:0]        SixTenths = 16'd39322;
  localparam logic signed [31:0] YLimit    = 32'sd327680;

  localparam logic [1:0] RegMode  = 2'd0;
  localparam logic [1:0] RegStep  = 2'd1;
  localparam logic [1:0] RegHoriz = 2'd2;

  typedef enum logic [1:0] {
    ModeLine   = 2'd0,
    ModeCircle = 2'd1,
    ModeSine   = 2'd2,
    ModeSpare  = 2'd3
  } mode_e;

  // CORDIC vector and side data traveling down the chain of cells.
  typedef struct packed {
    logic               vld;
    logic               vec;     // 1: vectoring (atan), 0: rotation
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [19:0] z;
  } cell_t;

  function automatic logic signed [19:0] atan_q16(input int i);
    case (i)
      0: atan_q16 = 20'sd51472;
      1: atan_q16 = 20'sd30386;
      2: atan_q16 = 20'sd16055;
      3: atan_q16 = 20'sd8150;
      4: atan_q16 = 20'sd4091;
      5: atan_q16 = 20'sd2047;
      6: atan_q16 = 20'sd1024;
      7: atan_q16 = 20'sd512;
      8: atan_q16 = 20'sd256;
      9: atan_q16 = 20'sd128;
      10: atan_q16 = 20'sd64;
      11: atan_q16 = 20'sd32;
      12: atan_q16 = 20'sd16;
      13: atan_q16 = 20'sd8;
      14: atan_q16 = 20'sd4;
      15: atan_q16 = 20'sd2;
      16: atan_q16 = 20'sd1;
      default: atan_q16 = 20'sd0;
    endcase
  endfunction

  function automatic logic signed [19:0] scale_q16(input logic [2:0] amp,
                                                  input logic signed [33:0] v);
    logic signed [37:0] p;
    logic signed [37:0] r;
    begin
      p = $signed({1'b0, amp}) * v + 38'sd8192;
      r = p >>> 14;
      if (r > 38'(YLimit)) r = 38'(YLimit);
      if (r < -38'(YLimit)) r = -38'(YLimit);
      scale_q16 = r[19:0];
    end
  endfunction

endpackage

// File: sv/rtg_cell.sv
// One CORDIC micro-rotation cell; carries its side data along.
// Depends on rtg_pkg.
module rtg_cell import rtg_pkg::*; #(
  parameter int Idx = 0,
  parameter int SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_t            c_i,
  input  logic [SideW-1:0] side_i,
  output cell_t            c_o,
  output logic [SideW-1:0] side_o
);
  cell_t              c_d;
  logic               vld_q;
  logic               vec_q;
  logic signed [33:0] x_q, y_q;
  logic signed [19:0] z_q;
  logic [SideW-1:0]   side_q;
  logic               up;
  logic signed [33:0] xs, ys;

  always_comb begin
    xs = c_i.x >>> Idx;
    ys = c_i.y >>> Idx;
    up = c_i.vec ? c_i.y[33] : ~c_i.z[19];
    c_d = c_i;
    if (up) begin
      c_d.x = c_i.x - ys;
      c_d.y = c_i.y + xs;
      c_d.z = c_i.z - atan_q16(Idx);
    end else begin
      c_d.x = c_i.x + ys;
      c_d.y = c_i.y - xs;
      c_d.z = c_i.z + atan_q16(Idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= c_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q  <= c_d.vec;
    x_q    <= c_d.x;
    y_q    <= c_d.y;
    z_q    <= c_d.z;
    side_q <= side_i;
  end

  assign c_o    = '{vld: vld_q, vec: vec_q, x: x_q, y: y_q, z: z_q};
  assign side_o = side_q;
endmodule

// File: sv/rtg_chain.sv
// Chain of CORDIC cells, one per iteration.
// Depends on rtg_pkg, rtg_cell.
module rtg_chain import rtg_pkg::*; #(
  parameter int Stages = CordicStagesDefault,
  parameter int SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_t            c_i,
  input  logic [SideW-1:0] side_i,
  output cell_t            c_o,
  output logic [SideW-1:0] side_o
);
  cell_t            cs [Stages+1];
  logic [SideW-1:0] ss [Stages+1];

  assign cs[0] = c_i;
  assign ss[0] = side_i;

  for (genvar g = 0; g < Stages; g++) begin : g_cell
    rtg_cell #(.Idx(g), .SideW(SideW)) u_cell (
      .clk_i, .rst_ni,
      .c_i(cs[g]), .side_i(ss[g]),
      .c_o(cs[g+1]), .side_o(ss[g+1])
    );
  end

  assign c_o    = cs[Stages];
  assign side_o = ss[Stages];
endmodule

// File: sv/reference_trajectory_generator.sv
// Reference trajectory generator, top level.
// Depends on rtg_pkg, rtg_chain (chain of rtg_cell CORDIC cells).
//
// Usage: pulse start with start_step_i while busy is low. The block then
// emits min(horizon_length, MAX_HORIZON, 64) reference states, one per cycle,
// each marked by a one-cycle valid_o strobe with horizon_index_o counting from
// 0 and last_of_horizon_o on the final beat. The receiver cannot stall; every
// beat must be taken the cycle it is shown.
// Pipeline: step index -> time multiply -> phase multiply -> modulo 2 pi
// (multiply by reciprocal, one correction) -> range fold -> CORDIC rotation
// chain (CORDIC_STAGES cells) -> scale -> 0.6 cos multiply -> CORDIC vectoring
// chain -> output register. Beats leave the output register one per cycle.
// Busy stays high while the index counter issues a horizon and drops in the
// cycle of the last issue, so the next request may start while the previous
// horizon still drains from the chain.
// A horizon_length of zero emits nothing.
// Reset: mode straight line, time_step 6554, horizon_length 16; pipe empties.
// Config must be written through the APB port while the block is idle;
// the block itself does not enforce this.
module reference_trajectory_generator import rtg_pkg::*; #(
  parameter int MAX_HORIZON   = MaxHorizonDefault,
  parameter int CORDIC_STAGES = CordicStagesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        start_step_i,
  output logic               valid_o,
  output logic signed [31:0] ref_x_o,
  output logic signed [19:0] ref_y_o,
  output logic signed [18:0] ref_heading_o,
  output logic [16:0]        ref_speed_o,
  output logic [5:0]         horizon_index_o,
  output logic               last_of_horizon_o
);
  localparam int CntW = $clog2(ResultCap + 1);
  // effective horizon cap, never above the 64 beats the index field can count
  localparam int HorizCap = (MAX_HORIZON < ResultCap) ? MAX_HORIZON : ResultCap;

  // ---------------- configuration registers
  logic [1:0]  mode_q;
  logic [15:0] tstep_q;
  logic [6:0]  hlen_q;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeLine;
      tstep_q <= 16'd6554;
      hlen_q  <= 7'd16;
    end else if (wr) begin
      case (paddr[3:2])
        RegMode:  mode_q  <= pwdata[1:0];
        RegStep:  tstep_q <= pwdata[15:0];
        RegHoriz: hlen_q  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegMode:  prdata = {30'd0, mode_q};
      RegStep:  prdata = {16'd0, tstep_q};
      RegHoriz: prdata = {25'd0, hlen_q};
      default:  prdata = 32'd0;
    endcase
  end

  // ---------------- issue counter
  logic [CntW-1:0] cnt_q, total_q, total_d;
  logic [15:0]     base_q;
  logic            busy_q;
  logic            last_issue;

  always_comb begin
    total_d = (hlen_q > 7'(HorizCap)) ? CntW'(HorizCap) : CntW'(hlen_q);
  end

  // free again in the cycle that issues the last beat of a horizon
  assign last_issue = busy_q && (cnt_q + 1'b1 == total_q);
  assign busy = busy_q & ~last_issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start && !busy) begin
      busy_q <= (total_d != '0);
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q  <= cnt_q + 1'b1;
      if (cnt_q + 1'b1 == total_q) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      base_q  <= start_step_i;
      total_q <= total_d;
    end
  end

  // side data travels with every beat: mode, index, last
  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] idx;
    logic       last;
  } tag_t;
  localparam int TagW = $bits(tag_t);

  tag_t tag0;
  assign tag0 = '{mode: mode_q, idx: cnt_q[5:0], last: (cnt_q + 1'b1 == total_q)};

  // ---------------- stage 1: time t = step * time_step
  logic        v1_q;
  tag_t        g1_q;
  logic [32:0] t1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= busy_q;
  end
  always_ff @(posedge clk_i) begin
    g1_q <= tag0;
    t1_q <= ({1'b0, base_q} + 17'(cnt_q)) * tstep_q;
  end

  // ---------------- stage 2: phase product (t*W)>>32
  logic        v2_q;
  tag_t        g2_q;
  logic [32:0] t2_q;
  logic [32:0] ph2_q;
  logic [64:0] pprod;
  assign pprod = t1_q * ((g1_q.mode == ModeCircle) ? WCircle : WSine);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    g2_q  <= g1_q;
    t2_q  <= t1_q;
    ph2_q <= pprod[64:32];
  end

  // ---------------- stage 3: quotient estimate by reciprocal
  // floor(ph / 2pi) ~ (ph * floor(2^51/411775)) >> 51, off by at most one
  localparam logic [32:0] Recip = 33'(64'd2251799813685248 / 64'd411775);
  logic        v3_q;
  tag_t        g3_q;
  logic [32:0] t3_q, ph3_q;
  logic [14:0] qt3_q;
  logic [65:0] qprod;
  assign qprod = ph2_q * Recip;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    g3_q  <= g2_q;
    t3_q  <= t2_q;
    ph3_q <= ph2_q;
    qt3_q <= qprod[65:51];
  end

  // ---------------- stage 4: remainder, correction, wrap and fold
  logic        v4_q;
  tag_t        g4_q;
  logic [32:0] t4_q;
  logic signed [19:0] a4_q;
  logic [33:0] rem;
  logic signed [19:0] a_w;
  always_comb begin
    rem = {1'b0, ph3_q} - 34'(qt3_q) * 34'(TwoPiQ16);
    if (rem >= 34'(TwoPiQ16)) rem = rem - 34'(TwoPiQ16);
    a_w = $signed({1'b0, rem[18:0]});
    if (a_w > PiQ16) a_w = a_w - $signed({1'b0, TwoPiQ16});
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    g4_q <= g3_q;
    t4_q <= t3_q;
    a4_q <= a_w;
  end

  // ---------------- rotation chain
  typedef struct packed {
    tag_t        g;
    logic [32:0] t;
    logic signed [19:0] a;
    logic        flip;
  } rside_t;
  localparam int RsW = $bits(rside_t);

  cell_t  rc_in, rc_out;
  rside_t rs_in, rs_out;
  logic [RsW-1:0] rs_out_b;
  always_comb begin
    rc_in.vld = v4_q;
    rc_in.vec = 1'b0;
    rc_in.x   = GainQ30;
    rc_in.y   = '0;
    rc_in.z   = a4_q;
    rs_in.g   = g4_q;
    rs_in.t   = t4_q;
    rs_in.a   = a4_q;
    rs_in.flip = 1'b0;
    if (a4_q > HalfPiQ16) begin
      rc_in.z = a4_q - PiQ16;
      rs_in.flip = 1'b1;
    end else if (a4_q < -HalfPiQ16) begin
      rc_in.z = a4_q + PiQ16;
      rs_in.flip = 1'b1;
    end
  end

  rtg_chain #(.Stages(CORDIC_STAGES), .SideW(RsW)) u_rot (
    .clk_i, .rst_ni, .c_i(rc_in), .side_i(rs_in), .c_o(rc_out), .side_o(rs_out_b)
  );
  assign rs_out = rside_t'(rs_out_b);

  // stage 5: scale, heading and the cosine for the 0.6 cos product
  typedef struct packed {
    tag_t        g;
    logic signed [31:0] x;
    logic signed [19:0] y;
    logic signed [19:0] h;
  } oside_t;
  localparam int OsW = $bits(oside_t);

  logic   v5_q;
  oside_t o5_q;
  logic signed [33:0] c5_q;
  logic signed [33:0] cosv, sinv;
  logic signed [19:0] hc;
  logic signed [31:0] xl;
  oside_t o5_d;
  always_comb begin
    cosv = rs_out.flip ? -rc_out.x : rc_out.x;
    sinv = rs_out.flip ? -rc_out.y : rc_out.y;
    hc = rs_out.a + HalfPiQ16;
    if (hc > PiQ16) hc = hc - $signed({1'b0, TwoPiQ16});
    xl = rs_out.t[32:31] != 2'b00 ? 32'sh7FFFFFFF : $signed(rs_out.t[31:0]);
    o5_d.g = rs_out.g;
    case (mode_e'(rs_out.g.mode))
      ModeCircle: begin
        o5_d.x = 32'(scale_q16(3'd5, cosv));
        o5_d.y = scale_q16(3'd5, sinv);
        o5_d.h = hc;
      end
      ModeSine: begin
        o5_d.x = xl;
        o5_d.y = scale_q16(3'd2, sinv);
        o5_d.h = '0;
      end
      default: begin
        o5_d.x = xl;
        o5_d.y = '0;
        o5_d.h = '0;
      end
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else         v5_q <= rc_out.vld;
  end
  always_ff @(posedge clk_i) begin
    o5_q <= o5_d;
    c5_q <= cosv;
  end

  // ---------------- stage 6: 0.6 cos = floor(cos*39322 / 2^16)
  logic   v6_q;
  oside_t o6_q;
  logic signed [33:0] s6_q;
  logic signed [50:0] sp;
  assign sp = c5_q * $signed({1'b0, SixTenths});
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else         v6_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    o6_q <= o5_q;
    s6_q <= 34'(sp >>> 16);
  end

  // ---------------- vectoring chain (atan)
  cell_t vc_in, vc_out;
  logic [OsW-1:0] vs_out_b;
  oside_t vs_out;
  always_comb begin
    vc_in.vld = v6_q;
    vc_in.vec = 1'b1;
    vc_in.x   = OneQ30;
    vc_in.y   = s6_q;
    vc_in.z   = '0;
  end

  rtg_chain #(.Stages(CORDIC_STAGES), .SideW(OsW)) u_vec (
    .clk_i, .rst_ni, .c_i(vc_in), .side_i(o6_q), .c_o(vc_out), .side_o(vs_out_b)
  );
  assign vs_out = oside_t'(vs_out_b);

  // ---------------- output register
  logic               vo_q;
  logic signed [31:0] xo_q;
  logic signed [19:0] yo_q;
  logic signed [18:0] ho_q;
  logic [5:0]         io_q;
  logic               lo_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else         vo_q <= vc_out.vld;
  end
  always_ff @(posedge clk_i) begin
    xo_q <= vs_out.x;
    yo_q <= vs_out.y;
    ho_q <= (vs_out.g.mode == ModeSine) ? vc_out.z[18:0] : vs_out.h[18:0];
    io_q <= vs_out.g.idx;
    lo_q <= vs_out.g.last;
  end

  assign valid_o           = vo_q;
  assign ref_x_o           = xo_q;
  assign ref_y_o           = yo_q;
  assign ref_heading_o     = ho_q;
  assign ref_speed_o       = 17'd65536;
  assign horizon_index_o   = io_q;
  assign last_of_horizon_o = lo_q;
endmodule
